FILE: src/ble_adv_report_filter_assert.svh
// assertion helpers shared by the filter modules
`ifndef BLE_ADV_REPORT_FILTER_ASSERT_SVH
`define BLE_ADV_REPORT_FILTER_ASSERT_SVH

// checked only out of reset
`define BLERF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define BLERF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: src/blerf_pkg.sv
`default_nettype none

package blerf_pkg;

    localparam int WHITELIST_SLOTS_DEFAULT = 4;
    localparam int QUEUE_DEPTH = 2;
    localparam int ADDR_W = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 48;
    localparam int SLOT_EN_W = 4;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_RSSI_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_ENABLE = 3'd1;
    localparam int REG_ADDRESS_SLOT_0 = 2;

    localparam logic signed [7:0] RSSI_THRESHOLD_RESET = -8'sd70;

    // result kinds on tuser
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_WRONG_TYPE = 3'd1,
        ST_NOT_META   = 3'd2,
        ST_NOT_ADV    = 3'd3,
        ST_TRUNCATED  = 3'd4
    } status_t;

    // one queue entry: what one accepted byte causes
    typedef struct packed {
        logic              has_report;
        logic              has_status;
        status_t           status;
        logic [7:0]        report_number;
        logic [7:0]        rssi;
        logic [ADDR_W-1:0] address;
    } entry_t;

    typedef struct packed {
        logic signed [7:0]    rssi_threshold;
        logic [SLOT_EN_W-1:0] slot_enable;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/blerf_front.sv
`default_nettype none

module blerf_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // packet_byte
    input  wire logic              s_tlast,   // end_of_packet
    output logic                   push_valid,
    input  wire logic              push_ready,
    output blerf_pkg::entry_t      push_data
);

    localparam logic [7:0] PKT_TYPE_EVENT = 8'h04;
    localparam logic [7:0] EVT_LE_META = 8'h3E;
    localparam logic [7:0] SUB_ADV_REPORT = 8'h02;
    localparam int ADDR_BYTES = blerf_pkg::ADDR_W / 8;

    typedef enum logic [12:0] {
        PH_TYPE  = 13'b0000000000001,
        PH_EVT   = 13'b0000000000010,
        PH_PLEN  = 13'b0000000000100,
        PH_SUB   = 13'b0000000001000,
        PH_COUNT = 13'b0000000010000,
        PH_ETYPE = 13'b0000000100000,
        PH_ATYPE = 13'b0000001000000,
        PH_ADDR  = 13'b0000010000000,
        PH_DLEN  = 13'b0000100000000,
        PH_DATA  = 13'b0001000000000,
        PH_RSSI  = 13'b0010000000000,
        PH_DONE  = 13'b0100000000000,
        PH_SKIP  = 13'b1000000000000
    } phase_t;

    phase_t                          phase_reg, phase_next, phase_step;
    logic [7:0]                      reports_left_reg, reports_left_next;
    logic [7:0]                      counter_reg, counter_next;
    logic [7:0]                      bytes_left_reg, bytes_left_next;
    logic [blerf_pkg::ADDR_W-1:0]    addr_reg, addr_next;
    blerf_pkg::status_t              latch_reg, latch_next, latch_step;
    blerf_pkg::status_t              status_out;
    logic                            accept;

    assign s_tready   = push_ready;
    assign accept     = s_tvalid && push_ready;
    assign push_valid = s_tvalid && ((phase_reg == PH_RSSI) || s_tlast);

    always_comb begin
        phase_step        = phase_reg;
        reports_left_next = reports_left_reg;
        counter_next      = counter_reg;
        bytes_left_next   = bytes_left_reg;
        addr_next         = addr_reg;
        latch_step        = latch_reg;
        case (phase_reg)
            PH_TYPE: begin
                if (s_tdata == PKT_TYPE_EVENT) begin
                    phase_step = PH_EVT;
                end else begin
                    latch_step = blerf_pkg::ST_WRONG_TYPE;
                    phase_step = PH_SKIP;
                end
            end
            PH_EVT: begin
                if (s_tdata == EVT_LE_META) begin
                    phase_step = PH_PLEN;
                end else begin
                    latch_step = blerf_pkg::ST_NOT_META;
                    phase_step = PH_SKIP;
                end
            end
            PH_PLEN: phase_step = PH_SUB;
            PH_SUB: begin
                if (s_tdata == SUB_ADV_REPORT) begin
                    phase_step = PH_COUNT;
                end else begin
                    latch_step = blerf_pkg::ST_NOT_ADV;
                    phase_step = PH_SKIP;
                end
            end
            PH_COUNT: begin
                reports_left_next = s_tdata;
                counter_next      = '0;
                phase_step        = (s_tdata == 8'd0) ? PH_DONE : PH_ETYPE;
            end
            PH_ETYPE: phase_step = PH_ATYPE;
            PH_ATYPE: begin
                bytes_left_next = 8'(ADDR_BYTES);
                addr_next       = '0;
                phase_step      = PH_ADDR;
            end
            PH_ADDR: begin
                // first byte ends up lowest
                addr_next       = {s_tdata, addr_reg[blerf_pkg::ADDR_W-1:8]};
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    phase_step = PH_DLEN;
                end
            end
            PH_DLEN: begin
                bytes_left_next = s_tdata;
                phase_step      = (s_tdata == 8'd0) ? PH_RSSI : PH_DATA;
            end
            PH_DATA: begin
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_reg == 8'd1) begin
                    phase_step = PH_RSSI;
                end
            end
            PH_RSSI: begin
                counter_next      = counter_reg + 8'd1;
                reports_left_next = reports_left_reg - 8'd1;
                phase_step        = (reports_left_reg == 8'd1) ? PH_DONE : PH_ETYPE;
            end
            default: begin
            end
        endcase

        if (latch_step != blerf_pkg::ST_OK) begin
            status_out = latch_step;
        end else if (phase_step == PH_DONE) begin
            status_out = blerf_pkg::ST_OK;
        end else begin
            status_out = blerf_pkg::ST_TRUNCATED;
        end

        phase_next = phase_step;
        latch_next = latch_step;
        if (s_tlast) begin
            phase_next        = PH_TYPE;
            reports_left_next = '0;
            counter_next      = '0;
            bytes_left_next   = '0;
            addr_next         = '0;
            latch_next        = blerf_pkg::ST_OK;
        end
    end

    always_comb begin
        push_data.has_report    = (phase_reg == PH_RSSI);
        push_data.has_status    = s_tlast;
        push_data.status        = status_out;
        push_data.report_number = counter_reg;
        push_data.rssi          = s_tdata;
        push_data.address       = addr_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_TYPE;
            reports_left_reg <= '0;
            counter_reg      <= '0;
            bytes_left_reg   <= '0;
            addr_reg         <= '0;
            latch_reg        <= blerf_pkg::ST_OK;
        end else if (accept) begin
            phase_reg        <= phase_next;
            reports_left_reg <= reports_left_next;
            counter_reg      <= counter_next;
            bytes_left_reg   <= bytes_left_next;
            addr_reg         <= addr_next;
            latch_reg        <= latch_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/blerf_queue.sv
`default_nettype none

`include "ble_adv_report_filter_assert.svh"

module blerf_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire blerf_pkg::entry_t push_data,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output blerf_pkg::entry_t      pop_data
);

    localparam int DEPTH = blerf_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    blerf_pkg::entry_t   mem [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                push_fire, pop_fire;

    assign push_ready = (count_reg != FULL_COUNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push_fire && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push_fire) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    `BLERF_ASSERT(a_count_bound, count_reg <= FULL_COUNT, "queue count beyond depth")
    `BLERF_ASSERT(a_count_up, (push_fire && !pop_fire) |=> (count_reg == $past(count_reg) + 1'b1), "queue count missed a push")
    `BLERF_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> (count_reg == '0), "queue not empty after reset")

endmodule

`default_nettype wire

FILE: src/blerf_back.sv
`default_nettype none

`include "ble_adv_report_filter_assert.svh"

module blerf_back #(
    parameter int WHITELIST_SLOTS = blerf_pkg::WHITELIST_SLOTS_DEFAULT
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire blerf_pkg::cfg_t              cfg,
    input  wire logic [blerf_pkg::ADDR_W-1:0] slot_addr [WHITELIST_SLOTS],
    input  wire logic                         pop_valid,
    output logic                              pop_ready,
    input  wire blerf_pkg::entry_t            pop_data,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [23:0]                       m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);

    logic                 m_tvalid_reg;
    logic                 m_tuser_reg;
    logic                 m_tlast_reg;
    logic                 det_reg;
    logic [1:0]           slot_reg;
    logic [7:0]           num_reg;
    logic [7:0]           rssi_reg;
    blerf_pkg::status_t   status_reg;
    logic                 pend_reg;
    blerf_pkg::status_t   pend_status_reg;
    logic                 out_free;
    logic                 hit;
    logic [1:0]           hit_slot;
    logic                 detected;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop_ready = out_free && !pend_reg;

    // lowest enabled slot that equals the report address
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = 0; i < WHITELIST_SLOTS; i++) begin
            if (!hit && cfg.slot_enable[i] && (slot_addr[i] == pop_data.address)) begin
                hit      = 1'b1;
                hit_slot = 2'(i);
            end
        end
        detected = hit && ($signed(pop_data.rssi) > $signed(cfg.rssi_threshold));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            pend_reg     <= 1'b0;
        end else if (out_free) begin
            if (pend_reg) begin
                m_tvalid_reg <= 1'b1;
                pend_reg     <= 1'b0;
            end else if (pop_valid) begin
                m_tvalid_reg <= 1'b1;
                pend_reg     <= pop_data.has_report && pop_data.has_status;
            end else begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (pend_reg || (pop_valid && !pop_data.has_report)) begin
                m_tuser_reg <= blerf_pkg::KIND_STATUS;
                m_tlast_reg <= 1'b1;
                det_reg     <= 1'b0;
                slot_reg    <= '0;
                num_reg     <= '0;
                rssi_reg    <= '0;
                status_reg  <= pend_reg ? pend_status_reg : pop_data.status;
            end else if (pop_valid) begin
                m_tuser_reg     <= blerf_pkg::KIND_REPORT;
                m_tlast_reg     <= !pop_data.has_status;
                det_reg         <= detected;
                slot_reg        <= hit_slot;
                num_reg         <= pop_data.report_number;
                rssi_reg        <= pop_data.rssi;
                status_reg      <= blerf_pkg::ST_OK;
                pend_status_reg <= pop_data.status;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {2'b00, status_reg, rssi_reg, num_reg, slot_reg, det_reg};

    `BLERF_ASSERT(a_pend_behind_report, pend_reg |-> (m_tvalid_reg && (m_tuser_reg == blerf_pkg::KIND_REPORT) && !m_tlast_reg), "pending status without a report ahead of it")
    `BLERF_ASSERT(a_status_is_last, (m_tvalid_reg && (m_tuser_reg == blerf_pkg::KIND_STATUS)) |-> m_tlast_reg, "status item not marked last")
    `BLERF_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (!m_tvalid_reg && !pend_reg), "output busy after reset")

endmodule

`default_nettype wire

FILE: src/ble_adv_report_filter.sv
// Advertising report filter: takes the bytes of one HCI LE meta event,
// one byte per item on s_*, with s_tlast on the final byte of the packet,
// and checks the header (packet type 0x04, event code 0x3E, length byte
// not checked, subevent 0x02, report count). For each complete report it
// gives a report item (tuser 0) with report index, RSSI, the lowest
// enabled whitelist slot whose address matches, and detected when a slot
// matches and RSSI is strictly above rssi_threshold. On the last byte it
// gives a status item (tuser 1, tlast 1): ok, wrong type, not meta, not
// advertising or truncated. One byte is accepted a cycle while the queue
// has room (s_tready is its push_ready); results go out one item a cycle
// while m_tready allows, so a byte that closes a report and the packet
// together gives two items, absorbed by the two-entry queue between
// parser and formatter. The user writes configuration through cfg_we /
// cfg_index / cfg_wdata only while no packet is in flight (unenforced).
`default_nettype none

module ble_adv_report_filter #(
    parameter int WHITELIST_SLOTS = blerf_pkg::WHITELIST_SLOTS_DEFAULT
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [blerf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [blerf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // packet bytes in
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [7:0]                           s_tdata,   // packet_byte
    input  wire logic                                 s_tlast,   // end_of_packet
    // results out
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // detected, matched_slot[2:1], report_number[10:3], signal_strength[18:11],
    // packet_status[21:19], zero fill
    output logic [23:0]                               m_tdata,
    output logic                                      m_tuser,   // result_kind
    output logic                                      m_tlast    // last_of_run
);

    // configuration registers
    blerf_pkg::cfg_t                 cfg_reg;
    logic [blerf_pkg::ADDR_W-1:0]    slot_addr_reg [WHITELIST_SLOTS];

    // parser to formatter queue
    logic                            push_valid, push_ready;
    blerf_pkg::entry_t               push_data;
    logic                            pop_valid, pop_ready;
    blerf_pkg::entry_t               pop_data;

    // indexes past the slots present are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.rssi_threshold <= blerf_pkg::RSSI_THRESHOLD_RESET;
            cfg_reg.slot_enable    <= '0;
            for (int i = 0; i < WHITELIST_SLOTS; i++) begin
                slot_addr_reg[i] <= '0;
            end
        end else if (cfg_we) begin
            if (cfg_index == blerf_pkg::REG_RSSI_THRESHOLD) begin
                cfg_reg.rssi_threshold <= cfg_wdata[7:0];
            end
            if (cfg_index == blerf_pkg::REG_SLOT_ENABLE) begin
                cfg_reg.slot_enable <= cfg_wdata[blerf_pkg::SLOT_EN_W-1:0];
            end
            for (int i = 0; i < WHITELIST_SLOTS; i++) begin
                if (cfg_index == blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0 + i)) begin
                    slot_addr_reg[i] <= cfg_wdata[blerf_pkg::ADDR_W-1:0];
                end
            end
        end
    end

    // header checks, field tracking, address capture
    blerf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // lets parser and output stall apart
    blerf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // whitelist compare, rssi test, splits report and status items
    blerf_back #(
        .WHITELIST_SLOTS (WHITELIST_SLOTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .slot_addr (slot_addr_reg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_ble_adv_report_filter.sv
`timescale 1ns / 1ps

module tb_ble_adv_report_filter;

    localparam int NUM_SLOTS       = blerf_pkg::WHITELIST_SLOTS_DEFAULT;
    localparam int RESET_CYCLES    = 6;
    // margin for the queue and the output register, generous
    localparam int DRAIN_CYCLES    = 10;
    localparam int HOLD_CYCLES     = 150;
    localparam int NUM_PHASES      = 6;
    localparam int BYTES_PER_PHASE = 215;
    localparam int CYCLE_LIMIT     = 400000;

    // register index with no register behind it, writes must be ignored
    localparam logic [blerf_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    // packet header bytes
    localparam logic [7:0] PKT_TYPE_EVENT = 8'h04;
    localparam logic [7:0] LE_META_EVT    = 8'h3E;
    localparam logic [7:0] ADV_REPORT     = 8'h02;

    typedef enum {
        P_TYPE, P_EVT, P_LEN, P_SUB, P_COUNT, P_ETYPE, P_ATYPE,
        P_ADDR, P_DLEN, P_DATA, P_RSSI, P_DONE, P_SKIP
    } parse_phase_t;

    // one result item, unpacked into its fields
    typedef struct packed {
        logic                kind;
        logic                detected;
        logic [1:0]          slot;
        logic [7:0]          number;
        logic signed [7:0]   rssi;
        blerf_pkg::status_t  status;
        logic                last;
    } adv_result_t;

    // packet parser model plus the queue of results still owed by the block
    class adv_report_scoreboard;
        logic signed [7:0]               thr;
        logic [blerf_pkg::SLOT_EN_W-1:0] en;
        logic [blerf_pkg::ADDR_W-1:0]    slot_addr[NUM_SLOTS];

        parse_phase_t                 phase;
        logic [7:0]                   reports_left;
        logic [7:0]                   report_idx;
        logic [7:0]                   field_left;
        logic [blerf_pkg::ADDR_W-1:0] addr_acc;
        blerf_pkg::status_t           status;

        adv_result_t owed_results[$];
        int          mismatches;

        function new();
            thr = blerf_pkg::RSSI_THRESHOLD_RESET;
            en  = '0;
            for (int i = 0; i < NUM_SLOTS; i++) slot_addr[i] = '0;
            mismatches = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            phase        = P_TYPE;
            reports_left = '0;
            report_idx   = '0;
            field_left   = '0;
            addr_acc     = '0;
            status       = blerf_pkg::ST_OK;
        endfunction

        function void write_reg(logic [blerf_pkg::CFG_INDEX_W-1:0] idx,
                                logic [blerf_pkg::CFG_DATA_W-1:0] val);
            if (idx == blerf_pkg::REG_RSSI_THRESHOLD) thr = val[7:0];
            else if (idx == blerf_pkg::REG_SLOT_ENABLE) en = val[blerf_pkg::SLOT_EN_W-1:0];
            else if (int'(idx) >= blerf_pkg::REG_ADDRESS_SLOT_0 &&
                     int'(idx) < blerf_pkg::REG_ADDRESS_SLOT_0 + NUM_SLOTS)
                slot_addr[int'(idx) - blerf_pkg::REG_ADDRESS_SLOT_0] =
                    val[blerf_pkg::ADDR_W-1:0];
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        // advance the parser by one accepted item and queue what it causes
        function void take_byte(logic [7:0] b, logic last);
            adv_result_t r;
            logic        hit;
            logic [1:0]  slot;
            case (phase)
                P_TYPE: begin
                    if (b == PKT_TYPE_EVENT) phase = P_EVT;
                    else begin
                        status = blerf_pkg::ST_WRONG_TYPE;
                        phase  = P_SKIP;
                    end
                end
                P_EVT: begin
                    if (b == LE_META_EVT) phase = P_LEN;
                    else begin
                        status = blerf_pkg::ST_NOT_META;
                        phase  = P_SKIP;
                    end
                end
                P_LEN: phase = P_SUB;
                P_SUB: begin
                    if (b == ADV_REPORT) phase = P_COUNT;
                    else begin
                        status = blerf_pkg::ST_NOT_ADV;
                        phase  = P_SKIP;
                    end
                end
                P_COUNT: begin
                    reports_left = b;
                    report_idx   = '0;
                    if (b == 8'd0) phase = P_DONE;
                    else phase = P_ETYPE;
                end
                P_ETYPE: phase = P_ATYPE;
                P_ATYPE: begin
                    field_left = 8'd6;
                    addr_acc   = '0;
                    phase      = P_ADDR;
                end
                P_ADDR: begin
                    addr_acc   = {b, addr_acc[blerf_pkg::ADDR_W-1:8]};
                    field_left = field_left - 8'd1;
                    if (field_left == 8'd0) phase = P_DLEN;
                end
                P_DLEN: begin
                    field_left = b;
                    if (b == 8'd0) phase = P_RSSI;
                    else phase = P_DATA;
                end
                P_DATA: begin
                    field_left = field_left - 8'd1;
                    if (field_left == 8'd0) phase = P_RSSI;
                end
                P_RSSI: begin
                    hit  = 1'b0;
                    slot = '0;
                    for (int i = 0; i < NUM_SLOTS; i++) begin
                        if (!hit && en[i] && slot_addr[i] == addr_acc) begin
                            hit  = 1'b1;
                            slot = i[1:0];
                        end
                    end
                    r          = '0;
                    r.kind     = blerf_pkg::KIND_REPORT;
                    r.detected = hit && ($signed(b) > thr);
                    r.slot     = slot;
                    r.number   = report_idx;
                    r.rssi     = b;
                    r.status   = blerf_pkg::ST_OK;
                    r.last     = !last;
                    owed_results.insert(owed_results.size(), r);
                    report_idx   = report_idx + 8'd1;
                    reports_left = reports_left - 8'd1;
                    if (reports_left == 8'd0) phase = P_DONE;
                    else phase = P_ETYPE;
                end
                default: ;
            endcase

            if (last) begin
                r      = '0;
                r.kind = blerf_pkg::KIND_STATUS;
                if (status != blerf_pkg::ST_OK) r.status = status;
                else if (phase == P_DONE) r.status = blerf_pkg::ST_OK;
                else r.status = blerf_pkg::ST_TRUNCATED;
                r.last = 1'b1;
                owed_results.insert(owed_results.size(), r);
                clear_parse();
            end
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(adv_result_t got);
            adv_result_t want;
            if (owed_results.size() == 0) begin
                $error("result item with nothing expected: kind %0d status %0d",
                       got.kind, got.status);
                mismatches++;
            end else begin
                want = owed_results.pop_front();
                compare_field("result_kind", want.kind, got.kind);
                compare_field("detected", want.detected, got.detected);
                compare_field("matched_slot", want.slot, got.slot);
                compare_field("report_number", want.number, got.number);
                compare_field("signal_strength", int'($signed(want.rssi)),
                              int'($signed(got.rssi)));
                compare_field("packet_status", int'(want.status), int'(got.status));
                compare_field("last_of_run", want.last, got.last);
            end
        endfunction
    endclass

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    // configuration port
    logic                              cfg_we    = 1'b0;
    logic [blerf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [blerf_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    // packet bytes in
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = '0;   // packet_byte
    logic       s_tlast  = 1'b0; // end_of_packet

    // results out
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // detected, matched_slot[2:1], report_number[10:3], signal_strength[18:11],
    // packet_status[21:19], zero fill
    logic [23:0] m_tdata;
    logic        m_tuser;         // result_kind
    logic        m_tlast;         // last_of_run

    adv_report_scoreboard sb = new();
    adv_result_t          seen_result;

    // idling of both sides, in percent of cycles
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // long receiver hold-off, requested by the stimulus, counted by the receiver
    int hold_req  = 0;
    int hold_ack  = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int bytes_sent  = 0;

    logic [7:0] pkt[$];

    ble_adv_report_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // both channels are sampled on the rising edge; input item noted before results
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.take_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                seen_result.kind     = m_tuser;
                seen_result.detected = m_tdata[0];
                seen_result.slot     = m_tdata[2:1];
                seen_result.number   = m_tdata[10:3];
                seen_result.rssi     = m_tdata[18:11];
                seen_result.status   = blerf_pkg::status_t'(m_tdata[21:19]);
                seen_result.last     = m_tlast;
                sb.check_result(seen_result);
            end
        end
    end

    // receiver: random stalls, or a long hold-off when one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // register write, only while the block is idle; model follows at once
    task automatic write_reg(input logic [blerf_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [blerf_pkg::CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge aclk);
        cfg_we = 1'b0;
        sb.write_reg(idx, val);
    endtask

    // stop offering, wait for every owed result, then let the pipeline empty
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // one item on the input channel; tvalid stays high into the next item unless the sender idles
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    endtask

    function automatic void append_byte(input logic [7:0] b);
        pkt.insert(pkt.size(), b);
    endfunction

    task automatic add_header(input logic [7:0] count);
        append_byte(PKT_TYPE_EVENT);
        append_byte(LE_META_EVT);
        append_byte(8'($urandom_range(255)));   // length, not checked
        append_byte(ADV_REPORT);
        append_byte(count);
    endtask

    task automatic add_report(input logic [blerf_pkg::ADDR_W-1:0] addr, input int dlen,
                              input logic [7:0] rssi);
        append_byte(8'($urandom_range(255)));   // event type
        append_byte(8'($urandom_range(255)));   // address type
        for (int k = 0; k < 6; k++) append_byte(addr[8*k +: 8]);
        append_byte(8'(dlen));
        for (int k = 0; k < dlen; k++) append_byte(8'($urandom_range(255)));
        append_byte(rssi);
    endtask

    // mostly whitelisted addresses, some near misses, some random
    function automatic logic [blerf_pkg::ADDR_W-1:0] pick_addr();
        logic [blerf_pkg::ADDR_W-1:0] a;
        int                           sel;
        sel = $urandom_range(9);
        a   = sb.slot_addr[$urandom_range(NUM_SLOTS - 1)];
        if (sel >= 7) a = blerf_pkg::ADDR_W'({$urandom(), $urandom()});
        else if (sel >= 5) a[8*$urandom_range(5) +: 8] ^= 8'($urandom_range(1, 255));
        return a;
    endfunction

    // rssi around the threshold a third of the time
    function automatic logic [7:0] pick_rssi();
        logic [7:0] v;
        v = sb.thr;
        if ($urandom_range(2) == 0) v = v + 8'($urandom_range(2)) - 8'd1;
        else v = 8'($urandom_range(255));
        return v;
    endfunction

    function automatic int pick_dlen();
        if ($urandom_range(99) < 85) return $urandom_range(3);
        return $urandom_range(4, 31);
    endfunction

    task automatic build_reports(input int n);
        for (int r = 0; r < n; r++) add_report(pick_addr(), pick_dlen(), pick_rssi());
    endtask

    // well-formed packets with random content, plus broken ones and noise
    task automatic random_packet();
        int sel;
        int count;
        int k;
        sel = $urandom_range(99);
        pkt.delete();
        if (sel < 60) begin
            if ($urandom_range(99) < 85) count = $urandom_range(1, 3);
            else count = $urandom_range(4, 8);
            add_header(8'(count));
            build_reports(count);
            // bytes after the last report are ignored
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(1, 3)) append_byte(8'($urandom_range(255)));
        end else if (sel < 75) begin
            // packet ends early, count anywhere from 1 to 255
            count = $urandom_range(1, 255);
            add_header(8'(count));
            build_reports(count < 3 ? count : 3);
            k = $urandom_range(1, pkt.size() - 1);
            while (pkt.size() > k) void'(pkt.pop_back());
        end else if (sel < 85) begin
            // one header byte broken
            add_header(8'($urandom_range(1, 2)));
            build_reports(1);
            case ($urandom_range(2))
                0:       k = 0;
                1:       k = 1;
                default: k = 3;
            endcase
            pkt[k] = pkt[k] ^ 8'($urandom_range(1, 255));
            while (pkt.size() > k + 1 + $urandom_range(4)) void'(pkt.pop_back());
        end else if (sel < 90) begin
            add_header(8'd0);
        end else begin
            repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(255)));
        end
        send_packet();
    endtask

    // register settings per phase, extremes among them
    task automatic apply_setting(input int p);
        logic [blerf_pkg::ADDR_W-1:0]    a[NUM_SLOTS];
        logic [7:0]                      thr;
        logic [blerf_pkg::SLOT_EN_W-1:0] en;
        for (int i = 0; i < NUM_SLOTS; i++)
            a[i] = blerf_pkg::ADDR_W'({$urandom(), $urandom()});
        thr = 8'($urandom_range(255));
        en  = 4'($urandom_range(15));
        case (p)
            0: begin
                thr = 8'h80;
                en  = 4'hF;
            end
            1: begin
                thr  = 8'h7F;
                a[0] = '1;
                a[1] = '1;
            end
            2: en = 4'h0;
            3: begin
                en   = 4'hF;
                a[0] = '0;
                a[3] = a[2];
            end
            4: begin
                thr  = 8'h00;
                a[0] = '0;
            end
            default: ;
        endcase
        write_reg(blerf_pkg::REG_RSSI_THRESHOLD, blerf_pkg::CFG_DATA_W'(thr));
        write_reg(blerf_pkg::REG_SLOT_ENABLE, blerf_pkg::CFG_DATA_W'(en));
        for (int i = 0; i < NUM_SLOTS; i++)
            write_reg(blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0 + i), a[i]);
    endtask

    initial begin
        int phase_start;

        tx_idle_pct = 29;
        rx_idle_pct = 77;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset threshold and reset addresses: slot 0 holds address zero
        write_reg(blerf_pkg::REG_SLOT_ENABLE, blerf_pkg::CFG_DATA_W'(4'b0001));
        pkt.delete();
        add_header(8'd1);
        add_report('0, 0, 8'hBB);   // -69, just above the reset threshold
        send_packet();
        wait_idle();

        // lowest threshold, slot 0 off, slots 1 and 3 equal
        write_reg(blerf_pkg::REG_RSSI_THRESHOLD, blerf_pkg::CFG_DATA_W'(8'h80));
        write_reg(blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0), 48'h0123_4567_89AB);
        write_reg(blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0 + 1), '1);
        write_reg(blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0 + 2),
                  blerf_pkg::CFG_DATA_W'({$urandom(), $urandom()}));
        write_reg(blerf_pkg::CFG_INDEX_W'(blerf_pkg::REG_ADDRESS_SLOT_0 + 3), '1);
        write_reg(blerf_pkg::REG_SLOT_ENABLE, blerf_pkg::CFG_DATA_W'(4'b1110));
        write_reg(REG_UNUSED, blerf_pkg::CFG_DATA_W'({$urandom(), $urandom()}));

        // wrong packet type, single byte
        pkt.delete();
        append_byte(8'hFF);
        send_packet();
        // not a meta event
        pkt.delete();
        append_byte(PKT_TYPE_EVENT);
        append_byte(8'hC3);
        send_packet();
        // not an advertising report
        pkt.delete();
        append_byte(PKT_TYPE_EVENT);
        append_byte(LE_META_EVT);
        append_byte(8'h00);
        append_byte(8'hFD);
        send_packet();
        // zero report count
        pkt.delete();
        add_header(8'd0);
        send_packet();
        // highest rssi, duplicate slots: lowest enabled one wins
        pkt.delete();
        add_header(8'd1);
        add_report('1, 0, 8'h7F);
        send_packet();
        // ends inside the address
        pkt.delete();
        add_header(8'd1);
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h12);
        send_packet();
        // ends on the type byte
        pkt.delete();
        append_byte(PKT_TYPE_EVENT);
        send_packet();
        wait_idle();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < 2) begin
                tx_idle_pct = 29;
                rx_idle_pct = 77;
            end else if (p < 4) begin
                tx_idle_pct = 77;
                rx_idle_pct = 29;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_setting(p);
            phase_start = bytes_sent;

            // receiver holds off while a long packet keeps coming, input must stall
            if (p == 1) begin
                hold_req++;
                pkt.delete();
                add_header(8'd4);
                for (int r = 0; r < 4; r++) add_report(pick_addr(), 3, pick_rssi());
                send_packet();
            end

            while (bytes_sent - phase_start < BYTES_PER_PHASE) begin
                random_packet();
                // now and then the sender pauses until the block has caught up
                if ($urandom_range(29) == 0) wait_idle();
            end
            s_tvalid = 1'b0;
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/blerf_pkg.sv
src/blerf_front.sv
src/blerf_queue.sv
src/blerf_back.sv
src/ble_adv_report_filter.sv
tb/sv/tb_ble_adv_report_filter.sv
